// ===== sv/point_to_depth_image_projector_macros.svh =====
// assertion macros for the point to depth image projector
// expects signals clk and rst in the scope of each use
`ifndef POINT_TO_DEPTH_IMAGE_PROJECTOR_MACROS_SVH
`define POINT_TO_DEPTH_IMAGE_PROJECTOR_MACROS_SVH

// condition holds at every clock edge outside reset
`define PDIP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PDIP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/pdip_pkg.sv =====
// shared constants, codes and types of the point to depth image projector
// no dependencies
package pdip_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int FRAME_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(FRAME_DEPTH);

  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int DEPTH_W = 16;
  localparam int CFG_W   = 16;
  localparam int XY_W    = 16;
  localparam int Z_W     = 17;

  // products of a coordinate by a focal length and of a center by the depth
  localparam int PROD_XY_W = XY_W + CFG_W + 1;
  localparam int PROD_Z_W  = Z_W + CFG_W + 1;

  // signed numerator of one axis and the dividend after dropping 4 fraction bits
  localparam int NUM_W = 35;
  localparam int DVD_W = NUM_W - 5;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] REG_FOCAL_X  = 2'd0;
  localparam logic [1:0] REG_FOCAL_Y  = 2'd1;
  localparam logic [1:0] REG_CENTER_X = 2'd2;
  localparam logic [1:0] REG_CENTER_Y = 2'd3;

  typedef struct packed {
    logic               en;
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [DEPTH_W-1:0] wdata;
  } mem_req_t;

endpackage

// ===== sv/pdip_divider.sv =====
// restoring unsigned divider, one quotient bit per cycle
// depends on pdip_pkg
module pdip_divider
  import pdip_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [Z_W-1:0]   divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [Z_W-1:0]   rem;
  logic [Z_W-1:0]   dsr;
  logic [DVD_W-1:0] acc;
  logic [Z_W:0]     shifted;
  logic [Z_W:0]     diff;
  logic             ge;

  assign shifted  = {rem, acc[DVD_W-1]};
  assign ge       = shifted >= {1'b0, dsr};
  assign diff     = ge ? shifted - {1'b0, dsr} : shifted;
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(DVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      acc <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      rem <= diff[Z_W-1:0];
      acc <= {acc[DVD_W-2:0], ge};
    end
  end

endmodule

// ===== sv/pdip_frame_mem.sv =====
// depth frame store, one port, registered read data
// depends on pdip_pkg
module pdip_frame_mem
  import pdip_pkg::*;
(
  input  logic               clk,
  input  mem_req_t           req,
  output logic [DEPTH_W-1:0] rdata
);

  logic [DEPTH_W-1:0] mem [FRAME_DEPTH];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

// ===== sv/point_to_depth_image_projector.sv =====
// channel  dir  handshake                 payload
// s_       in   s_tvalid/s_tready         s_tdata point and read address, s_tuser op, flag
// m_       out  m_tvalid/m_tready         m_tdata depth, column, row, m_tuser written
// cfg_     in   cfg_valid/cfg_ready       cfg_index, cfg_data
// one request at a time; each op walks the states below from one accept to the next
// a waiting result lets the next request in; a second one holds in the done step
// write: mul, sum, div, addr, access, done; div waits on the 30-step divider of each axis
// read and zero-depth write: addr, access, done; skipped points and unused ops: done only
// clear: all FRAME_WIDTH*FRAME_HEIGHT entries zeroed, one memory entry written per cycle, then done
// synchronous reset clears control and loads default configuration; the frame holds garbage until cleared
// depends on pdip_pkg, pdip_divider, pdip_frame_mem and the assertion macro header
`include "point_to_depth_image_projector_macros.svh"

module point_to_depth_image_projector
  import pdip_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [71:0]      s_tdata,   // x_mm, y_mm, z_mm, read_column, read_row, zero fill
  input  logic [2:0]       s_tuser,   // operation, point_valid
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [39:0]      m_tdata,   // depth_value, pixel_column, pixel_row, zero fill
  output logic [0:0]       m_tuser,   // pixel_written
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL    = 8'b0000_0010,
    S_SUM    = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_ADDR   = 8'b0001_0000,
    S_ACCESS = 8'b0010_0000,
    S_DONE   = 8'b0100_0000,
    S_CLEAR  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0] focal_x_q4, focal_y_q4, center_x_q4, center_y_q4;

  logic [1:0]            in_op;
  logic                  in_point_valid;
  logic signed [XY_W-1:0] in_x, in_y;
  logic signed [Z_W-1:0] in_z;
  logic [COL_W-1:0]      in_rcol, in_rcol_sat;
  logic [ROW_W-1:0]      in_rrow, in_rrow_sat;
  logic                  in_accept;

  logic signed [XY_W-1:0] x_r, y_r;
  logic signed [Z_W-1:0]  z_r;
  logic [DEPTH_W-1:0]     depth_r;
  logic [COL_W-1:0]       col_r;
  logic [ROW_W-1:0]       row_r;
  logic                   written_r;
  logic                   is_read;
  logic                   is_write;
  logic [ADDR_W-1:0]      addr_r;
  logic [ADDR_W-1:0]      clr_cnt;

  logic signed [XY_W+CFG_W:0]  prod_xf, prod_yf;
  logic signed [Z_W+CFG_W:0]   prod_cxz, prod_cyz;
  logic signed [NUM_W-1:0]     num_x, num_y;
  logic [NUM_W-1:0]            mag_x, mag_y;
  logic [Z_W-1:0]              z_abs;

  logic             div_start;
  logic             div_x_done, div_y_done;
  logic [DVD_W-1:0] quo_x, quo_y;
  logic [COL_W-1:0] quo_col;
  logic [ROW_W-1:0] quo_row;

  mem_req_t           mem_req;
  logic [DEPTH_W-1:0] mem_rdata;

  logic               out_load;
  logic [DEPTH_W-1:0] out_depth;
  logic [COL_W-1:0]   out_col;
  logic [ROW_W-1:0]   out_row;
  logic               out_written;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x_q4  <= CFG_W'(6189);
      focal_y_q4  <= CFG_W'(6144);
      center_x_q4 <= CFG_W'(5467);
      center_y_q4 <= CFG_W'(3824);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FOCAL_X:  focal_x_q4  <= cfg_data;
        REG_FOCAL_Y:  focal_y_q4  <= cfg_data;
        REG_CENTER_X: center_x_q4 <= cfg_data;
        REG_CENTER_Y: center_y_q4 <= cfg_data;
        default:      focal_x_q4  <= focal_x_q4;
      endcase
    end
  end

  // input unpacking
  assign in_op          = s_tuser[1:0];
  assign in_point_valid = s_tuser[2];
  assign in_x           = s_tdata[15:0];
  assign in_y           = s_tdata[31:16];
  assign in_z           = s_tdata[48:32];
  assign in_rcol        = s_tdata[58:49];
  assign in_rrow        = s_tdata[67:59];
  assign in_rcol_sat    = (in_rcol > COL_W'(FRAME_WIDTH - 1)) ? COL_W'(FRAME_WIDTH - 1) : in_rcol;
  assign in_rrow_sat    = (in_rrow > ROW_W'(FRAME_HEIGHT - 1)) ? ROW_W'(FRAME_HEIGHT - 1) : in_rrow;

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;

  // projection arithmetic
  assign num_x = NUM_W'(prod_xf) + NUM_W'(prod_cxz);
  assign num_y = NUM_W'(prod_yf) + NUM_W'(prod_cyz);
  assign mag_x = num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
  assign mag_y = num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
  assign z_abs = z_r[Z_W-1] ? Z_W'(-z_r) : Z_W'(z_r);

  assign div_start = (state == S_SUM);

  pdip_divider u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_x[NUM_W-2:4]),
    .divisor  (z_abs),
    .done     (div_x_done),
    .quotient (quo_x)
  );

  pdip_divider u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_y[NUM_W-2:4]),
    .divisor  (z_abs),
    .done     (div_y_done),
    .quotient (quo_y)
  );

  assign quo_col = (quo_x > DVD_W'(FRAME_WIDTH - 1)) ? COL_W'(FRAME_WIDTH - 1)
                                                      : quo_x[COL_W-1:0];
  assign quo_row = (quo_y > DVD_W'(FRAME_HEIGHT - 1)) ? ROW_W'(FRAME_HEIGHT - 1)
                                                       : quo_y[ROW_W-1:0];

  // frame memory
  always_comb begin
    mem_req = '0;
    if (state == S_CLEAR) begin
      mem_req.en    = 1'b1;
      mem_req.we    = 1'b1;
      mem_req.addr  = clr_cnt;
      mem_req.wdata = '0;
    end else if (state == S_ACCESS) begin
      mem_req.en    = 1'b1;
      mem_req.we    = is_write;
      mem_req.addr  = addr_r;
      mem_req.wdata = depth_r;
    end
  end

  pdip_frame_mem u_frame (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // sequencer
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_op)
            OP_CLEAR: state_next = S_CLEAR;
            OP_WRITE: begin
              if (!in_point_valid) state_next = S_DONE;
              else if (in_z == '0) state_next = S_ADDR;
              else                 state_next = S_MUL;
            end
            OP_READ:  state_next = S_ADDR;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_MUL:    state_next = S_SUM;
      S_SUM:    state_next = S_DIV;
      S_DIV:    if (div_x_done) state_next = S_ADDR;
      S_ADDR:   state_next = S_ACCESS;
      S_ACCESS: state_next = S_DONE;
      S_DONE:   if (out_load) state_next = S_IDLE;
      S_CLEAR:  if (clr_cnt == ADDR_W'(FRAME_DEPTH - 1)) state_next = S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          x_r       <= in_x;
          y_r       <= in_y;
          z_r       <= in_z;
          depth_r   <= '0;
          col_r     <= '0;
          row_r     <= '0;
          written_r <= 1'b0;
          is_read   <= 1'b0;
          is_write  <= 1'b0;
          clr_cnt   <= '0;
          if (in_op == OP_WRITE && in_point_valid) begin
            written_r <= 1'b1;
            is_write  <= 1'b1;
            depth_r   <= in_z[Z_W-1] ? '0 : in_z[DEPTH_W-1:0];
          end else if (in_op == OP_READ) begin
            is_read <= 1'b1;
            col_r   <= in_rcol_sat;
            row_r   <= in_rrow_sat;
          end
        end
      end
      S_MUL: begin
        prod_xf  <= PROD_XY_W'(x_r) * PROD_XY_W'($signed({1'b0, focal_x_q4}));
        prod_yf  <= PROD_XY_W'(y_r) * PROD_XY_W'($signed({1'b0, focal_y_q4}));
        prod_cxz <= PROD_Z_W'($signed({1'b0, center_x_q4})) * PROD_Z_W'(z_r);
        prod_cyz <= PROD_Z_W'($signed({1'b0, center_y_q4})) * PROD_Z_W'(z_r);
      end
      S_DIV: begin
        if (div_x_done) begin
          col_r <= quo_col;
          row_r <= quo_row;
        end
      end
      S_ADDR: begin
        addr_r <= ADDR_W'(row_r) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(col_r);
      end
      S_CLEAR: begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      default: begin
        addr_r <= addr_r;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_depth   <= is_read ? mem_rdata : depth_r;
      out_col     <= col_r;
      out_row     <= row_r;
      out_written <= written_r;
    end
  end

  assign m_tdata = {5'b0, out_row, out_col, out_depth};
  assign m_tuser = out_written;

  // checks
  `PDIP_ASSERT_IMPLIES(a_mem_write_state, mem_req.we, (state == S_CLEAR) || (state == S_ACCESS && is_write), "frame written outside a clear sweep or a point write")
  `PDIP_ASSERT_ALWAYS(a_div_lockstep, div_x_done == div_y_done, "axis dividers out of step")
  `PDIP_ASSERT_IMPLIES(a_div_done_state, div_x_done, state == S_DIV, "divider finished outside the divide wait")
  `PDIP_ASSERT_IMPLIES(a_out_in_frame, m_tvalid, (out_col < COL_W'(FRAME_WIDTH)) && (out_row < ROW_W'(FRAME_HEIGHT)), "reported pixel outside the frame")

endmodule
